[rtl/core/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/tog_pkg.sv]
package tog_pkg;

    localparam int NUM_W          = 2;
    localparam int TAG_W          = 22;
    localparam int QUEUE_DEPTH_DEF = 10;
    localparam int NUM_REQUESTERS = 3;

    localparam logic [NUM_W-1:0] FIRST_TURN = NUM_W'(1);

    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic             grant_valid;
        logic [NUM_W-1:0] grant_num;
        logic [TAG_W-1:0] grant_tag;
        logic             dropped;
    } t_result;

    // Flags from the shared step unit.
    typedef struct packed {
        logic eq;
        logic lt;
    } t_step_res;

endpackage

[rtl/core/turn_order_grant_controller_top.sv]
// Turn-order grant controller. Requesters 1 to 3 take turns in cyclic order; an access
// request for the current turn is granted straight away, any other request is parked in a
// waiting table of QUEUE_DEPTH entries, and a full table drops the request and flags it.
// A finished notice advances the turn, then one shared compare unit walks the table
// from its oldest entry, one entry per cycle through the table's single read port, and
// grants and removes the first match while later entries move down one place. Every
// transaction yields exactly one result. An access request goes from the decide state to the
// done state and then the output register; a finished notice scans the waiting entries between
// them. The block takes one transaction at a time, while a finished result may still wait in
// the output register.
module turn_order_grant_controller_top #(
    parameter int QUEUE_DEPTH = tog_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_req_type,
    input  logic [tog_pkg::NUM_W-1:0]  i_requester_num,
    input  logic [tog_pkg::TAG_W-1:0]  i_requester_tag,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_grant_valid,
    output logic [tog_pkg::NUM_W-1:0]  o_grant_num,
    output logic [tog_pkg::TAG_W-1:0]  o_grant_tag,
    output logic                       o_dropped
);
    import tog_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    t_result          result;
    logic             we;
    logic [IDX_W-1:0] waddr;
    t_entry           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
    t_entry           rdata;
    logic [NUM_W-1:0] step_a;
    logic [NUM_W-1:0] step_b;
    logic [CNT_W-1:0] step_idx;
    logic [CNT_W:0]   step_lim;
    logic [CNT_W:0]   step_inc;
    t_step_res        step_res;

    tog_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_requester_num (i_requester_num),
        .i_requester_tag (i_requester_tag),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result        (result),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_re            (re),
        .o_raddr         (raddr),
        .i_rdata         (rdata),
        .o_step_a        (step_a),
        .o_step_b        (step_b),
        .o_step_idx      (step_idx),
        .o_step_lim      (step_lim),
        .i_step_inc      (step_inc),
        .i_step_res      (step_res)
    );

    tog_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tog_step #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_step (
        .i_a   (step_a),
        .i_b   (step_b),
        .i_idx (step_idx),
        .i_lim (step_lim),
        .o_inc (step_inc),
        .o_res (step_res)
    );

    assign o_grant_valid = result.grant_valid;
    assign o_grant_num   = result.grant_num;
    assign o_grant_tag   = result.grant_tag;
    assign o_dropped     = result.dropped;

endmodule

[rtl/core/tog_step.sv]
module tog_step #(
    parameter int QUEUE_DEPTH = tog_pkg::QUEUE_DEPTH_DEF
) (
    input  logic [tog_pkg::NUM_W-1:0]          i_a,
    input  logic [tog_pkg::NUM_W-1:0]          i_b,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_idx,
    input  logic [$clog2(QUEUE_DEPTH+1):0]     i_lim,
    output logic [$clog2(QUEUE_DEPTH+1):0]     o_inc,
    output tog_pkg::t_step_res                 o_res
);
    import tog_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One number compare and one increment-and-bound check, shared by every step.
    assign o_inc    = {1'b0, i_idx} + (CNT_W + 1)'(1);
    assign o_res.eq = (i_a == i_b);
    assign o_res.lt = (o_inc < i_lim);

endmodule

[rtl/core/tog_queue.sv]
module tog_queue #(
    parameter int QUEUE_DEPTH = tog_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]   i_waddr,
    input  tog_pkg::t_entry                  i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]   i_raddr,
    output tog_pkg::t_entry                  o_rdata
);
    import tog_pkg::*;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/tog_seq.sv]
module tog_seq #(
    parameter int QUEUE_DEPTH = tog_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_req_type,
    input  logic [tog_pkg::NUM_W-1:0]        i_requester_num,
    input  logic [tog_pkg::TAG_W-1:0]        i_requester_tag,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tog_pkg::t_result                 o_result,
    output logic                             o_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   o_waddr,
    output tog_pkg::t_entry                  o_wdata,
    output logic                             o_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   o_raddr,
    input  tog_pkg::t_entry                  i_rdata,
    output logic [tog_pkg::NUM_W-1:0]        o_step_a,
    output logic [tog_pkg::NUM_W-1:0]        o_step_b,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_step_idx,
    output logic [$clog2(QUEUE_DEPTH+1):0]   o_step_lim,
    input  logic [$clog2(QUEUE_DEPTH+1):0]   i_step_inc,
    input  tog_pkg::t_step_res               i_step_res
);
    import tog_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [CNT_W:0] LIM_FULL = (CNT_W + 1)'(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [NUM_W-1:0] r_turn, n_turn;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_rd, n_rd;
    logic [IDX_W-1:0] r_wr, n_wr;
    logic             r_out_valid, n_out_valid;
    logic             r_kind, n_kind;
    logic [NUM_W-1:0] r_num, n_num;
    logic [TAG_W-1:0] r_tag, n_tag;
    t_result          r_res, n_res;
    t_result          r_out, n_out;

    logic             out_free;
    logic [NUM_W-1:0] turn_next;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign turn_next = (r_turn == NUM_W'(NUM_REQUESTERS)) ? FIRST_TURN
                                                         : r_turn + NUM_W'(1);

    always_comb begin
        n_state     = r_state;
        n_turn      = r_turn;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_kind      = r_kind;
        n_num       = r_num;
        n_tag       = r_tag;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        o_we       = 1'b0;
        o_waddr    = r_wr;
        o_wdata    = i_rdata;
        o_re       = 1'b0;
        o_raddr    = i_step_inc[IDX_W-1:0];
        o_step_a   = r_num;
        o_step_b   = r_turn;
        o_step_idx = r_count;
        o_step_lim = LIM_FULL;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_req_type;
                    n_num   = i_requester_num;
                    n_tag   = i_requester_tag;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_res = '0;
                if (r_kind == REQ_ACCESS) begin
                    // The step unit checks the turn and whether the table has room.
                    if (i_step_res.eq) begin
                        n_res.grant_valid = 1'b1;
                        n_res.grant_num   = r_num;
                        n_res.grant_tag   = r_tag;
                    end else if (!i_step_res.lt) begin
                        n_res.dropped = 1'b1;
                    end else begin
                        o_we          = 1'b1;
                        o_waddr       = r_count[IDX_W-1:0];
                        o_wdata.num   = r_num;
                        o_wdata.tag   = r_tag;
                        n_count       = i_step_inc[CNT_W-1:0];
                    end
                    n_state = S_DONE;
                end else begin
                    n_turn = turn_next;
                    if (r_count != '0) begin
                        o_re    = 1'b1;
                        o_raddr = '0;
                        n_rd    = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                o_step_a   = i_rdata.num;
                o_step_idx = CNT_W'(r_rd);
                o_step_lim = {1'b0, r_count};
                if (i_step_res.eq) begin
                    n_res.grant_valid = 1'b1;
                    n_res.grant_num   = i_rdata.num;
                    n_res.grant_tag   = i_rdata.tag;
                    if (i_step_res.lt) begin
                        // Later entries move down one place, starting at the hit.
                        o_re    = 1'b1;
                        n_rd    = i_step_inc[IDX_W-1:0];
                        n_wr    = r_rd;
                        n_state = S_MOVE;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_DONE;
                    end
                end else if (i_step_res.lt) begin
                    o_re = 1'b1;
                    n_rd = i_step_inc[IDX_W-1:0];
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOVE: begin
                o_step_a   = i_rdata.num;
                o_step_idx = CNT_W'(r_rd);
                o_step_lim = {1'b0, r_count};
                o_we       = 1'b1;
                o_waddr    = r_wr;
                o_wdata    = i_rdata;
                n_wr       = r_rd;
                if (i_step_res.lt) begin
                    o_re = 1'b1;
                    n_rd = i_step_inc[IDX_W-1:0];
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_turn      <= FIRST_TURN;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_turn      <= n_turn;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd   <= n_rd;
        r_wr   <= n_wr;
        r_kind <= n_kind;
        r_num  <= n_num;
        r_tag  <= n_tag;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

[rtl/core/tog_checker.sv]
`include "assert_macros.svh"

module tog_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_stall,
    input logic                       i_out_valid,
    input logic                       i_out_stall,
    input logic                       i_grant_valid,
    input logic [tog_pkg::NUM_W-1:0]  i_grant_num,
    input logic [tog_pkg::TAG_W-1:0]  i_grant_tag,
    input logic                       i_dropped
);
    import tog_pkg::*;

    // A result without a grant carries no requester number or tag.
    `ASSERT_IMP(a_no_grant_zero, i_clk, i_rst_n, i_out_valid && !i_grant_valid, i_grant_num == '0 && i_grant_tag == '0)

    // A dropped request is never granted as well.
    `ASSERT_IMP(a_drop_no_grant, i_clk, i_rst_n, i_out_valid && i_dropped, !i_grant_valid)

    // Only a real turn number is ever granted.
    `ASSERT_IMP(a_grant_num_set, i_clk, i_rst_n, i_out_valid && i_grant_valid, i_grant_num != '0)

    // After taking a transaction the block is busy in the next cycle.
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)

    // A stalled result stays on the port.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_grant_tag))

endmodule

bind turn_order_grant_controller_top tog_checker u_tog_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .i_in_stall    (o_in_stall),
    .i_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .i_grant_valid (o_grant_valid),
    .i_grant_num   (o_grant_num),
    .i_grant_tag   (o_grant_tag),
    .i_dropped     (o_dropped)
);
